// File: design/albd_pkg.sv
// Shared types and constants of the audio level beat detector.
// No dependencies.
package albd_pkg;
    localparam int NUM_BARS = 16;
    localparam int HISTORY_LEN = 43;
    localparam int BAR_W = 4;
    localparam int WIN_W = 6;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_PEAK_DECAY = 3'd1;
    localparam logic [2:0] REG_PEAK_FLOOR = 3'd2;
    localparam logic [2:0] REG_FLASH_DECAY = 3'd3;
    localparam logic [2:0] REG_SMOOTH_GAIN = 3'd4;
    localparam logic [2:0] REG_MAX_HEIGHT = 3'd5;

    typedef struct packed {
        logic [BAR_W:0] count;
        logic [NUM_BARS-1:0][15:0] levels;
    } frame_t;

    typedef struct packed {
        logic [7:0] beat_threshold;
        logic [15:0] peak_decay;
        logic [15:0] peak_floor;
        logic [15:0] flash_decay;
        logic [15:0] smooth_gain;
        logic [15:0] max_height;
    } cfg_t;
endpackage

// File: design/albd_front.sv
// Front end: accumulates sample magnitudes into bar levels, divides each
// group serially, and hands the finished frame to the queue. Uses albd_pkg.
module albd_front import albd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [15:0]  s_sample,
    input  logic         s_bar_end,
    input  logic         s_frame_end,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         f_valid,
    input  logic         f_ready,
    output frame_t       f_frame
);
    typedef enum logic [1:0] {IDLE, DIV, PUSH} state_t;
    state_t state_reg;
    logic [31:0] sum_reg;
    logic [15:0] cnt_reg;
    logic [BAR_W:0] cursor_reg;
    logic [NUM_BARS-1:0][15:0] levels_reg;
    logic frame_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] dcnt_reg;
    logic [5:0] step_reg;

    logic [16:0] mag;
    logic [31:0] sum_next;
    logic [15:0] cnt_next;
    logic [47:0] trial;
    logic [31:0] rem_sh;

    assign mag = s_sample[15] ? 17'h10000 - {1'b0, s_sample} : {1'b0, s_sample};
    assign s_ready = (state_reg == IDLE);
    assign f_valid = (state_reg == PUSH);
    assign f_frame.count = cursor_reg;
    assign f_frame.levels = levels_reg;

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cnt_reg != 16'hFFFF) begin
            sum_next = sum_reg + 32'(mag);
            cnt_next = cnt_reg + 16'd1;
        end
        rem_sh = {rem_reg[30:0], quo_reg[31]};
        trial = 48'(rem_sh) - 48'(dcnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            sum_reg <= '0;
            cnt_reg <= '0;
            cursor_reg <= '0;
            levels_reg <= '0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        if (s_bar_end || s_frame_end) begin
                            sum_reg <= '0;
                            cnt_reg <= '0;
                            frame_reg <= s_frame_end;
                            rem_reg <= '0;
                            quo_reg <= sum_next;
                            dcnt_reg <= cnt_next;
                            step_reg <= '0;
                            state_reg <= DIV;
                        end else begin
                            sum_reg <= sum_next;
                            cnt_reg <= cnt_next;
                        end
                    end
                end
                DIV: begin
                    if (!trial[47]) begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd31) begin
                        state_reg <= frame_reg ? PUSH : IDLE;
                        if (cursor_reg < (BAR_W+1)'(NUM_BARS)) begin
                            levels_reg[cursor_reg[BAR_W-1:0]] <= (dcnt_reg == 16'd0) ? 16'd0 :
                                (!trial[47] ? {quo_reg[14:0], 1'b1} : {quo_reg[14:0], 1'b0});
                            cursor_reg <= cursor_reg + 1'b1;
                        end
                    end
                end
                PUSH: begin
                    if (f_ready) begin
                        levels_reg <= '0;
                        cursor_reg <= '0;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

// File: design/albd_queue.sv
// Two-entry frame queue between the front and back ends. Uses albd_pkg.
module albd_queue import albd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   w_valid,
    output logic   w_ready,
    input  frame_t w_frame,
    output logic   r_valid,
    input  logic   r_ready,
    output frame_t r_frame
);
    frame_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign w_ready = (cnt_reg != 2'd2);
    assign r_valid = (cnt_reg != 2'd0);
    assign r_frame = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= w_frame;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// File: design/albd_back.sv
// Back end: energy, beat test over the energy window, peak and flash
// tracking, and per-bar height smoothing with a serial divider. Uses albd_pkg.
module albd_back import albd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_valid,
    output logic             q_ready,
    input  frame_t           q_frame,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [BAR_W-1:0] m_bar_index,
    output logic [15:0]      m_bar_height,
    output logic             m_beat,
    output logic [7:0]       m_flash_level,
    output logic [7:0]       m_glow_inner,
    output logic [7:0]       m_glow_mid,
    output logic [7:0]       m_glow_outer,
    output logic             m_last
);
    typedef enum logic [3:0] {
        IDLE, ENERGY, WIN_RD, WIN_UPD, BEAT_MUL, BEAT_CMP, PEAK, FLASH, GLOW,
        BAR_MUL, BAR_DIV, BAR_SMUL, BAR_OUT
    } state_t;
    state_t state_reg;
    frame_t frame_reg;
    logic [BAR_W-1:0] idx_reg;
    logic [31:0] energy_reg;
    logic [15:0] max_reg;
    logic [31:0] win_mem [HISTORY_LEN];
    logic [HISTORY_LEN-1:0] win_vld_reg;
    logic [31:0] win_old_reg;
    logic [WIN_W-1:0] wptr_reg;
    logic [39:0] total_reg;
    logic [31:0] prev_reg;
    logic [47:0] lhs_reg;
    logic [47:0] rhs_reg;
    logic beat_reg;
    logic [15:0] peak_reg;
    logic [15:0] flash_reg;
    logic [23:0] b_reg;
    logic [NUM_BARS-1:0][15:0] hgt_reg;
    logic [31:0] num_reg;
    logic [31:0] rem_reg;
    logic [5:0] step_reg;
    logic dir_reg;
    logic [31:0] prod_reg;
    logic [7:0] fl_reg, gi_reg, gm_reg, go_reg;

    logic [15:0] lvl;
    logic [31:0] sq;
    logic [31:0] rem_sh;
    logic [32:0] trial;
    logic [31:0] pk_dec;
    logic [31:0] fl_dec;
    logic [15:0] floor_v;
    logic [15:0] peak_new;
    logic [16:0] tgt;
    logic [15:0] h;
    logic [16:0] diff;
    logic [15:0] h_new;
    logic [39:0] gi_full;

    always_comb begin
        lvl = frame_reg.levels[idx_reg];
        sq = 32'(lvl) * 32'(lvl);
        rem_sh = {rem_reg[30:0], num_reg[31]};
        trial = {1'b0, rem_sh} - {17'd0, peak_reg};
        pk_dec = 32'(peak_reg) * 32'(cfg.peak_decay);
        fl_dec = 32'(flash_reg) * 32'(cfg.flash_decay);
        floor_v = (cfg.peak_floor == 16'd0) ? 16'd1 : cfg.peak_floor;
        peak_new = (max_reg > peak_reg) ? max_reg : pk_dec[31:16];
        if (peak_new < floor_v) peak_new = floor_v;
        tgt = (num_reg > 32'(cfg.max_height)) ? {1'b0, cfg.max_height} : num_reg[16:0];
        h = hgt_reg[idx_reg];
        diff = (tgt >= {1'b0, h}) ? tgt - {1'b0, h} : {1'b0, h} - tgt;
        h_new = dir_reg ? h + prod_reg[31:16] : h - prod_reg[31:16];
        gi_full = 40'(b_reg) * 40'd45875;
    end

    assign q_ready = (state_reg == IDLE);
    assign m_valid = (state_reg == BAR_OUT);
    assign m_bar_index = idx_reg;
    assign m_bar_height = h_new;
    assign m_beat = beat_reg;
    assign m_flash_level = fl_reg;
    assign m_glow_inner = gi_reg;
    assign m_glow_mid = gm_reg;
    assign m_glow_outer = go_reg;
    assign m_last = (idx_reg == BAR_W'(NUM_BARS-1));

    always_ff @(posedge aclk) begin
        if (state_reg == WIN_RD) win_old_reg <= win_vld_reg[wptr_reg] ? win_mem[wptr_reg] : '0;
        if (state_reg == WIN_UPD) win_mem[wptr_reg] <= energy_reg;
        if (!aresetn) begin
            state_reg <= IDLE;
            win_vld_reg <= '0;
            wptr_reg <= '0;
            total_reg <= '0;
            prev_reg <= '0;
            peak_reg <= '0;
            flash_reg <= '0;
            hgt_reg <= '0;
            idx_reg <= '0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (q_valid) begin
                        frame_reg <= q_frame;
                        idx_reg <= '0;
                        energy_reg <= '0;
                        max_reg <= '0;
                        state_reg <= ENERGY;
                    end
                end
                ENERGY: begin
                    energy_reg <= energy_reg + (sq >> 8);
                    if (lvl > max_reg) max_reg <= lvl;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == BAR_W'(NUM_BARS-1)) state_reg <= WIN_RD;
                end
                WIN_RD: state_reg <= WIN_UPD;
                WIN_UPD: begin
                    total_reg <= total_reg - 40'(win_old_reg) + 40'(energy_reg);
                    win_vld_reg[wptr_reg] <= 1'b1;
                    wptr_reg <= (wptr_reg == WIN_W'(HISTORY_LEN-1)) ? '0 : wptr_reg + 1'b1;
                    state_reg <= BEAT_MUL;
                end
                BEAT_MUL: begin
                    lhs_reg <= 48'(energy_reg) * 48'(16 * HISTORY_LEN);
                    rhs_reg <= 48'(total_reg) * 48'(cfg.beat_threshold);
                    state_reg <= BEAT_CMP;
                end
                BEAT_CMP: begin
                    beat_reg <= (lhs_reg > rhs_reg) && (energy_reg > prev_reg);
                    prev_reg <= energy_reg;
                    state_reg <= PEAK;
                end
                PEAK: begin
                    peak_reg <= peak_new;
                    flash_reg <= beat_reg ? 16'd32768 : fl_dec[31:16];
                    state_reg <= FLASH;
                end
                FLASH: begin
                    b_reg <= 24'(flash_reg) * 24'd255;
                    state_reg <= GLOW;
                end
                GLOW: begin
                    fl_reg <= (b_reg[23:15] > 9'd255) ? 8'd255 : b_reg[22:15];
                    gi_reg <= (gi_full[39:31] > 9'd255) ? 8'd255 : gi_full[38:31];
                    gm_reg <= b_reg[23:16];
                    go_reg <= {1'b0, b_reg[23:17]};
                    idx_reg <= '0;
                    state_reg <= BAR_MUL;
                end
                BAR_MUL: begin
                    num_reg <= 32'(lvl) * 32'(cfg.max_height);
                    rem_reg <= '0;
                    step_reg <= '0;
                    state_reg <= BAR_DIV;
                end
                BAR_DIV: begin
                    if (!trial[32]) begin
                        rem_reg <= trial[31:0];
                        num_reg <= {num_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[30:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd31) state_reg <= BAR_SMUL;
                end
                BAR_SMUL: begin
                    dir_reg <= (tgt >= {1'b0, h});
                    prod_reg <= 32'(diff) * 32'(cfg.smooth_gain);
                    state_reg <= BAR_OUT;
                end
                BAR_OUT: begin
                    if (m_ready) begin
                        hgt_reg[idx_reg] <= h_new;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= m_last ? IDLE : BAR_MUL;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

// File: design/audio_level_beat_detector.sv
// Top level of the audio level beat detector: config registers, front end,
// frame queue and back end. Uses albd_pkg, albd_front, albd_queue, albd_back.
//
// Ordinary samples are taken while the front end is idle; a bar_end or
// frame_end sample starts the serial level divider, which holds s_ready low,
// and a frame_end sample holds it low until the frame is handed on. At frame
// end the back end works through energy, beat, peak and flash, then per bar a
// multiply, the 32-step height divider, smoothing and output, plus any output
// stall; the two-frame queue lets the front end keep taking samples meanwhile.
module audio_level_beat_detector import albd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_sample,
    input  logic        s_bar_end,
    input  logic        s_frame_end,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_bar_index,
    output logic [15:0] m_bar_height,
    output logic        m_beat,
    output logic [7:0]  m_flash_level,
    output logic [7:0]  m_glow_inner,
    output logic [7:0]  m_glow_mid,
    output logic [7:0]  m_glow_outer,
    output logic        m_last
);
    cfg_t cfg_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    frame_t f_frame, q_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beat_threshold <= 8'd24;
            cfg_reg.peak_decay <= 16'd65208;
            cfg_reg.peak_floor <= 16'd33;
            cfg_reg.flash_decay <= 16'd55705;
            cfg_reg.smooth_gain <= 16'd16384;
            cfg_reg.max_height <= 16'd2560;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: cfg_reg.beat_threshold <= cfg_data[7:0];
                REG_PEAK_DECAY: cfg_reg.peak_decay <= cfg_data;
                REG_PEAK_FLOOR: cfg_reg.peak_floor <= cfg_data;
                REG_FLASH_DECAY: cfg_reg.flash_decay <= cfg_data;
                REG_SMOOTH_GAIN: cfg_reg.smooth_gain <= cfg_data;
                REG_MAX_HEIGHT: cfg_reg.max_height <= cfg_data;
                default: ;
            endcase
        end
    end

    albd_front u_front (
        .aclk, .aresetn, .s_sample, .s_bar_end, .s_frame_end, .s_valid, .s_ready,
        .f_valid, .f_ready, .f_frame
    );

    albd_queue u_queue (
        .aclk, .aresetn, .w_valid(f_valid), .w_ready(f_ready), .w_frame(f_frame),
        .r_valid(q_valid), .r_ready(q_ready), .r_frame(q_frame)
    );

    albd_back u_back (
        .aclk, .aresetn, .cfg(cfg_reg), .q_valid, .q_ready, .q_frame,
        .m_valid, .m_ready, .m_bar_index, .m_bar_height, .m_beat, .m_flash_level,
        .m_glow_inner, .m_glow_mid, .m_glow_outer, .m_last
    );
endmodule
